>>> src/glrd_pkg.sv
// ---------------------------------------------------------------------------
// glrd_pkg: shared types and constants of the gray logo run-length decoder
// field widths, token layout and the token word passed from front to back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package glrd_pkg;

  // pixel position counter width and derived limits
  localparam int unsigned POSITION_BITS = 12;
  localparam int unsigned FRAME_W       = 12;
  localparam int unsigned LEN_W         = 10;
  localparam int unsigned LEVEL_W       = 4;
  localparam int unsigned GRAY_W        = 8;
  localparam int unsigned GRAY_SHIFT    = 4;
  localparam int unsigned BYTE_W        = 8;

  // arithmetic width for position against frame compares
  localparam int unsigned CALC_W =
    ((POSITION_BITS > FRAME_W) ? POSITION_BITS : FRAME_W) + 2;

  localparam logic [POSITION_BITS-1:0] POS_MAX     = '1;
  localparam logic [FRAME_W-1:0]       FRAME_RESET = FRAME_W'(100 * 17);

  // token type bits in the first coded byte
  localparam int unsigned SHORT_BIT = 0;
  localparam int unsigned LONG_BIT  = 1;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one complete token, ready to be laid out as a run
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [LEVEL_W-1:0] level;
    logic               eof;
  } glrd_token_t;

endpackage

>>> src/glrd_ifs.sv
// ---------------------------------------------------------------------------
// glrd channel interfaces
// coded byte channel in, run channel out, both valid/ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface glrd_byte_if;
  logic                             valid;
  logic                             ready;
  logic [glrd_pkg::BYTE_W-1:0]      rle_byte;
  logic                             last_byte;

  modport source (output valid, output rle_byte, output last_byte, input ready);
  modport sink   (input valid, input rle_byte, input last_byte, output ready);
endinterface

interface glrd_run_if;
  logic                             valid;
  logic                             ready;
  logic [glrd_pkg::FRAME_W-1:0]     run_start;
  logic [glrd_pkg::LEN_W-1:0]       run_length;
  logic [glrd_pkg::GRAY_W-1:0]      gray_level;
  logic                             end_of_frame;

  modport source (output valid, output run_start, output run_length,
                  output gray_level, output end_of_frame, input ready);
  modport sink   (input valid, input run_start, input run_length,
                  input gray_level, input end_of_frame, output ready);
endinterface

>>> src/gray_logo_rle_decoder_unit.sv
// ---------------------------------------------------------------------------
// gray_logo_rle_decoder_unit: run-length decoder for a 4-bit gray logo
//
// byte_i takes one coded word per cycle (rle_byte, last_byte) under
// valid/ready. run_o gives one run word (run_start, run_length,
// gray_level, end_of_frame) per complete token; the first half of a long
// token gives none. cfg_we_i/cfg_wdata_i write the frame size; the user
// must write it only while the block is idle, the block does not enforce it.
// A run is written into the token queue when the word that completes it
// is taken, then registered in the run layout stage that holds the
// position counter.
// Throughput: one coded word per cycle while the queue has room, set by
// the single position update per token in the layout stage.
// Reset clears the held half token, the position and the queue, and
// loads a frame size of 1700 pixels.
// When the receiver stalls the output register holds its run, the
// two-entry queue fills and byte_i.ready then drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gray_logo_rle_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glrd_pkg::FRAME_W-1:0]  cfg_wdata_i,
  glrd_byte_if.sink                     byte_i,
  glrd_run_if.source                    run_o
);

  logic [glrd_pkg::FRAME_W-1:0] frame_q;
  logic                         push_valid;
  logic                         push_ready;
  glrd_pkg::glrd_token_t        push_tok;
  logic                         pop_valid;
  logic                         pop_ready;
  glrd_pkg::glrd_token_t        pop_tok;

  // frame size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= glrd_pkg::FRAME_RESET;
    end else if (cfg_we_i) begin
      frame_q <= cfg_wdata_i;
    end
  end

  // token assembly
  glrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_tok_o   (push_tok),
    .push_ready_i (push_ready)
  );

  // token queue
  glrd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_tok_i   (push_tok),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_tok_o    (pop_tok),
    .pop_ready_i  (pop_ready)
  );

  // run layout
  glrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_q),
    .pop_valid_i (pop_valid),
    .pop_tok_i   (pop_tok),
    .pop_ready_o (pop_ready),
    .run_o       (run_o)
  );

endmodule

>>> src/glrd_front.sv
// ---------------------------------------------------------------------------
// glrd_front: token assembly
// takes coded bytes, joins the two halves of long tokens, pushes tokens
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glrd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  glrd_byte_if.sink              byte_i,
  output logic                   push_valid_o,
  output glrd_pkg::glrd_token_t  push_tok_o,
  input  logic                   push_ready_i
);

  logic                          pending_q, pending_d;
  logic [glrd_pkg::BYTE_W-1:0]   held_q, held_d;
  logic                          accept;
  logic                          is_short;
  logic                          is_long;
  logic                          hold;
  logic [2*glrd_pkg::BYTE_W-1:0] word;

  // a word is taken whenever the queue has room
  assign byte_i.ready = push_ready_i;
  assign accept       = byte_i.valid && push_ready_i;

  // classify the word and build the token
  always_comb begin
    is_short = byte_i.rle_byte[glrd_pkg::SHORT_BIT];
    is_long  = !is_short && byte_i.rle_byte[glrd_pkg::LONG_BIT];
    hold     = accept && !pending_q && is_long && !byte_i.last_byte;
    word     = {byte_i.rle_byte, held_q};

    push_tok_o.eof = byte_i.last_byte;
    if (pending_q) begin
      push_tok_o.len   = word[11:2];
      push_tok_o.level = word[15:12];
    end else if (is_short) begin
      push_tok_o.len   = glrd_pkg::LEN_W'(byte_i.rle_byte[3:1]);
      push_tok_o.level = byte_i.rle_byte[7:4];
    end else begin
      // zero-length byte, or long token cut off by the last word
      push_tok_o.len   = '0;
      push_tok_o.level = '0;
    end

    push_valid_o = accept && !hold;

    pending_d = pending_q;
    held_d    = held_q;
    if (accept) begin
      if (hold) begin
        pending_d = 1'b1;
        held_d    = byte_i.rle_byte;
      end else begin
        pending_d = 1'b0;
        held_d    = '0;
      end
    end
  end

  // low half holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
    end else begin
      pending_q <= pending_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> src/glrd_queue.sv
// ---------------------------------------------------------------------------
// glrd_queue: token queue
// small first-in first-out store between token assembly and run layout
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glrd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  glrd_pkg::glrd_token_t  push_tok_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output glrd_pkg::glrd_token_t  pop_tok_o,
  input  logic                   pop_ready_i
);

  glrd_pkg::glrd_token_t           entries_q [glrd_pkg::QUEUE_DEPTH];
  logic [glrd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [glrd_pkg::QCNT_W-1:0]     count_q;
  logic                            do_push;
  logic                            do_pop;

  // occupancy flags
  assign push_ready_o = (count_q != glrd_pkg::QCNT_W'(glrd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_tok_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        if (wr_ptr_q == glrd_pkg::QPTR_W'(glrd_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr_q <= '0;
        end else begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr_q == glrd_pkg::QPTR_W'(glrd_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr_q <= '0;
        end else begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/glrd_back.sv
// ---------------------------------------------------------------------------
// glrd_back: run layout
// places each token at the pixel position, clips it to the frame and
// holds the run in the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glrd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [glrd_pkg::FRAME_W-1:0]  frame_i,
  input  logic                          pop_valid_i,
  input  glrd_pkg::glrd_token_t         pop_tok_i,
  output logic                          pop_ready_o,
  glrd_run_if.source                    run_o
);

  logic [glrd_pkg::POSITION_BITS-1:0] pos_q, pos_d;
  logic                               out_valid_q;
  logic [glrd_pkg::FRAME_W-1:0]       start_q, start_d;
  logic [glrd_pkg::LEN_W-1:0]         written_q, written_d;
  logic [glrd_pkg::GRAY_W-1:0]        gray_q, gray_d;
  logic                               eof_q;
  logic                               take;
  logic [glrd_pkg::CALC_W-1:0]        pos_w;
  logic [glrd_pkg::CALC_W-1:0]        frame_w;
  logic [glrd_pkg::CALC_W-1:0]        len_w;
  logic [glrd_pkg::CALC_W-1:0]        pos1_w;
  logic [glrd_pkg::CALC_W-1:0]        start_w;
  logic [glrd_pkg::CALC_W-1:0]        avail_w;
  logic [glrd_pkg::CALC_W-1:0]        next_w;

  // output register frees when empty or when its word is taken
  assign pop_ready_o = !out_valid_q || run_o.ready;
  assign take        = pop_valid_i && pop_ready_o;

  // run placement and clipping
  always_comb begin
    pos_w   = glrd_pkg::CALC_W'(pos_q);
    frame_w = glrd_pkg::CALC_W'(frame_i);
    len_w   = glrd_pkg::CALC_W'(pop_tok_i.len);
    pos1_w  = pos_w + 1'b1;
    start_w = (pos1_w > frame_w) ? frame_w : pos1_w;
    avail_w = frame_w - pos1_w;
    next_w  = pos_w + len_w;

    start_d = start_w[glrd_pkg::FRAME_W-1:0];
    if (pos1_w < frame_w) begin
      written_d = (len_w < avail_w) ? pop_tok_i.len : avail_w[glrd_pkg::LEN_W-1:0];
    end else begin
      written_d = '0;
    end
    gray_d = {pop_tok_i.level, {glrd_pkg::GRAY_SHIFT{1'b0}}};

    // position saturates, and returns to zero at end of frame
    if (pop_tok_i.eof) begin
      pos_d = '0;
    end else if (next_w > glrd_pkg::CALC_W'(glrd_pkg::POS_MAX)) begin
      pos_d = glrd_pkg::POS_MAX;
    end else begin
      pos_d = next_w[glrd_pkg::POSITION_BITS-1:0];
    end
  end

  // position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (run_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      start_q   <= start_d;
      written_q <= written_d;
      gray_q    <= gray_d;
      eof_q     <= pop_tok_i.eof;
    end
  end

  assign run_o.valid        = out_valid_q;
  assign run_o.run_start    = start_q;
  assign run_o.run_length   = written_q;
  assign run_o.gray_level   = gray_q;
  assign run_o.end_of_frame = eof_q;

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the gray logo run-length decoder
// coded words go in through a queue-fed driver with random gaps; runs are
// checked field by field against a predictor of the token decode and the
// clipped pixel layout, over several frame sizes including the extremes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 250;

  typedef struct {
    logic [glrd_pkg::BYTE_W-1:0] code;
    logic                        last;
  } coded_word_t;

  typedef struct {
    logic [glrd_pkg::FRAME_W-1:0] start;
    logic [glrd_pkg::LEN_W-1:0]   length;
    logic [glrd_pkg::GRAY_W-1:0]  gray;
    logic                         eof;
  } run_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [glrd_pkg::FRAME_W-1:0] cfg_wdata_i;

  glrd_byte_if byte_if ();
  glrd_run_if  run_if ();

  gray_logo_rle_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_if),
    .run_o       (run_if)
  );

  // decoder state as predicted
  logic [glrd_pkg::FRAME_W-1:0]       frame_size = glrd_pkg::FRAME_RESET;
  logic                               half_held  = 1'b0;
  logic [glrd_pkg::BYTE_W-1:0]        low_half   = '0;
  logic [glrd_pkg::POSITION_BITS-1:0] run_pos    = '0;

  coded_word_t pending_words[$];
  run_t        expected_runs[$];

  logic [31:0] cycle_cnt = '0;
  int unsigned words_taken = 0;
  int unsigned runs_checked = 0;
  int unsigned eof_runs = 0;
  int unsigned clipped_runs = 0;
  int unsigned input_stalls = 0;
  int unsigned frame_settings = 1;
  int unsigned errors = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        long_hold = 1'b0;

  // clock
  always #6 clk_i = ~clk_i;

  // works out the run a coded word completes, if any, and advances the state
  function automatic bit decode_word(input logic [glrd_pkg::BYTE_W-1:0] code,
                                     input logic last, output run_t run);
    int unsigned len, lvl, pos, start, avail, written, nxt;
    logic [15:0] token;
    len = 0;
    lvl = 0;
    if (half_held) begin
      token = {code, low_half};
      len = token[11:2];
      lvl = token[15:12];
      half_held = 1'b0;
      low_half = '0;
    end else if (code[glrd_pkg::SHORT_BIT]) begin
      len = code[3:1];
      lvl = code[7:4];
    end else if (code[glrd_pkg::LONG_BIT] && !last) begin
      half_held = 1'b1;
      low_half = code;
      return 1'b0;
    end
    // lay the run out after the current position, clipped to the frame
    pos = run_pos;
    start = pos + 1;
    if (start > frame_size) start = frame_size;
    written = 0;
    if (pos + 1 < frame_size) begin
      avail = frame_size - 1 - pos;
      written = (len < avail) ? len : avail;
    end
    nxt = pos + len;
    run_pos = (nxt > glrd_pkg::POS_MAX) ? glrd_pkg::POS_MAX
                                        : glrd_pkg::POSITION_BITS'(nxt);
    run.start = glrd_pkg::FRAME_W'(start);
    run.length = glrd_pkg::LEN_W'(written);
    run.gray = glrd_pkg::GRAY_W'(lvl << glrd_pkg::GRAY_SHIFT);
    run.eof = last;
    if (last) begin
      run_pos = '0;
      half_held = 1'b0;
      low_half = '0;
    end
    return 1'b1;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still expected", cycle_cnt,
               expected_runs.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // driver: offers queued words with random gaps, predicts on acceptance
  always @(posedge clk_i) begin
    coded_word_t w;
    run_t r;
    if (rst_ni) begin
      if (byte_if.valid && !byte_if.ready) input_stalls++;
      if (byte_if.valid && byte_if.ready) begin
        words_taken++;
        if (decode_word(byte_if.rle_byte, byte_if.last_byte, r)) expected_runs.push_back(r);
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          byte_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          byte_if.rle_byte <= w.code;
          byte_if.last_byte <= w.last;
          byte_if.valid <= 1'b1;
          src_gap = pick_gap(cycle_cnt[8:7] == 2'b00);
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, checks each run against the oldest expectation
  always @(posedge clk_i) begin
    run_t e;
    if (rst_ni) begin
      if (run_if.valid && run_if.ready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("run with nothing expected, run_start", run_if.run_start, 0);
        end else begin
          e = expected_runs.pop_front();
          runs_checked++;
          if (e.eof) eof_runs++;
          if (e.length == 0) clipped_runs++;
          if (run_if.run_start !== e.start)
            report_mismatch("run_start", run_if.run_start, e.start);
          if (run_if.run_length !== e.length)
            report_mismatch("run_length", run_if.run_length, e.length);
          if (run_if.gray_level !== e.gray)
            report_mismatch("gray_level", run_if.gray_level, e.gray);
          if (run_if.end_of_frame !== e.eof)
            report_mismatch("end_of_frame", run_if.end_of_frame, e.eof);
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        run_if.ready <= 1'b0;
      end else begin
        run_if.ready <= !long_hold;
        sink_gap = pick_gap(cycle_cnt[9:8] == 2'b01);
      end
    end
  end

  // long receiver hold-off so that the block fills and stalls its input
  initial begin
    wait (words_taken >= 880);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  task automatic push_word(input logic [glrd_pkg::BYTE_W-1:0] code, input logic last);
    coded_word_t w;
    w.code = code;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic push_long(input logic [glrd_pkg::LEN_W-1:0] len,
                           input logic [glrd_pkg::LEVEL_W-1:0] lvl,
                           input logic last);
    push_word({len[5:0], 2'b10}, 1'b0);
    push_word({lvl, len[9:6]}, last);
  endtask

  // wait until every word is taken and every run has come, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    while (pending_words.size() != 0 || byte_if.valid || expected_runs.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame_size(input logic [glrd_pkg::FRAME_W-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    frame_size = v;
    frame_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random words: mostly well-formed tokens, some cut-off tokens and noise
  task automatic random_phase(input int unsigned n_words);
    int unsigned r;
    int unsigned len;
    for (int unsigned pushed = 0; pushed < n_words; ) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_word({4'($urandom), 3'($urandom), 1'b1}, $urandom_range(0, 29) == 0);
        pushed++;
      end else if (r < 75) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
        push_long(glrd_pkg::LEN_W'(len), 4'($urandom), $urandom_range(0, 29) == 0);
        pushed += 2;
      end else if (r < 82) begin
        push_word({6'($urandom), 2'b00}, $urandom_range(0, 29) == 0);
        pushed++;
      end else if (r < 87) begin
        push_word({6'($urandom), 2'b10}, 1'b1);
        pushed++;
      end else begin
        push_word(8'($urandom), $urandom_range(0, 15) == 0);
        pushed++;
      end
      // keep the driver fed without racing far ahead of it
      while (pending_words.size() > 64) @(posedge clk_i);
    end
  endtask

  // reset and stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    byte_if.valid = 1'b0;
    byte_if.rle_byte = '0;
    byte_if.last_byte = 1'b0;
    run_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset frame size
    push_word(8'h01, 1'b0);                        // short run of nothing
    push_word(8'hFF, 1'b0);                        // longest short run, top level
    push_word(8'h00, 1'b0);                        // zero-length byte
    push_word(8'hFC, 1'b0);                        // zero-length byte, upper bits set
    push_long(10'd0, 4'd0, 1'b0);                  // empty long run
    repeat (5) push_long(10'd1023, 4'd15, 1'b0);   // past the frame, position saturates
    push_word(8'h3B, 1'b0);                        // short run at the saturated position
    push_word(8'hA5, 1'b1);                        // frame ends on a short run
    push_word(8'h7E, 1'b1);                        // long token cut off by the frame end
    push_word(8'h00, 1'b1);                        // zero-length byte ends a frame
    push_long(10'd513, 4'd9, 1'b1);                // long token ends a frame
    push_word(8'h02, 1'b1);                        // bare long first half as a frame end

    // frame size sweep, extremes included
    write_frame_size(12'd4095);
    random_phase(220);
    write_frame_size(12'd1);
    random_phase(120);
    write_frame_size(12'd0);
    random_phase(60);
    write_frame_size(12'd20);
    random_phase(160);
    write_frame_size(glrd_pkg::FRAME_W'($urandom_range(1, 4095)));
    random_phase(250);
    write_frame_size(glrd_pkg::FRAME_RESET);
    random_phase(270);

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d coded words over %0d frame sizes, %0d runs checked", words_taken,
             frame_settings, runs_checked);
    $display("%0d frame ends, %0d empty or clipped runs, %0d cycles of input stall",
             eof_runs, clipped_runs, input_stalls);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> gray_logo_rle_decoder_unit.f
src/glrd_pkg.sv
src/glrd_ifs.sv
src/glrd_front.sv
src/glrd_queue.sv
src/glrd_back.sv
src/gray_logo_rle_decoder_unit.sv
tb/sv/tb_top.sv
